// ===== hdl/a2a_pkg.sv =====
// ----------------------------------------------------------------------------
// a2a_pkg
// Types, tables and codes shared by the vector-to-angle pipeline.
// ----------------------------------------------------------------------------
package a2a_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned MagW   = CoordW + 1;
  localparam int unsigned RemW   = MagW + 6;
  localparam int unsigned QuoW   = 6;
  localparam int unsigned AngleW = 8;

  localparam logic [AngleW-1:0] CodeNegX   = 8'd63;
  localparam logic [AngleW-1:0] CodePosX   = 8'd191;
  localparam logic [AngleW-1:0] CodeNegY   = 8'd127;
  localparam logic [AngleW-1:0] CodePosY   = 8'd0;
  localparam logic [QuoW-1:0]   IdxMax     = 6'd45;

  typedef enum logic [2:0] {
    OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
  } octant_e;

  localparam logic [5:0] AngleTab [46] = '{
    6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,  6'd7,
    6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd11, 6'd12, 6'd12, 6'd13, 6'd14,
    6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19, 6'd20, 6'd20,
    6'd21, 6'd22, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd26, 6'd27,
    6'd28, 6'd28, 6'd29, 6'd30, 6'd32
  };

  localparam octant_e KeyMap [8] = '{
    OCT_2, OCT_3, OCT_1, OCT_0, OCT_5, OCT_4, OCT_6, OCT_7
  };

  typedef struct packed {
    logic              axis;
    logic [AngleW-1:0] axis_code;
    logic [2:0]        key;
    logic [RemW-1:0]   rem;
    logic [MagW-1:0]   den;
    logic [QuoW-1:0]   quo;
  } div_t;

endpackage

// ===== hdl/atan2_to_8bit_angle.sv =====
// ----------------------------------------------------------------------------
// atan2_to_8bit_angle
// Vector (x, y) to 8-bit binary angle, 256 steps per turn, pipelined.
// ----------------------------------------------------------------------------
// channel | valid        | stall         | payload
// in      | in_valid_i   | in_stall_o    | vec_x_i, vec_y_i
// out     | out_valid_o  | out_stall_i   | angle_code_o
//
// One request per cycle while in_stall_o is low; each result is registered in every stage below.
// Stages: prepare and scale, three two-bit division stages, table and octant.
// Reset clears the stage valid bits only.
// Each stage holds while the one after it is full and held; bubbles collapse.
// ----------------------------------------------------------------------------
module atan2_to_8bit_angle import a2a_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] vec_x_i,
  input  logic signed [CoordW-1:0] vec_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [AngleW-1:0]        angle_code_o
);

  logic [3:0] vld;
  div_t       dat [4];
  logic [4:0] en;

  assign en[4] = !out_valid_o || !out_stall_i;
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_stall_o = !en[0];

  a2a_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .valid_o (vld[0]),
    .data_o  (dat[0])
  );

  a2a_div_step u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[1]),
    .valid_i (vld[0]),
    .data_i  (dat[0]),
    .valid_o (vld[1]),
    .data_o  (dat[1])
  );

  a2a_div_step u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[2]),
    .valid_i (vld[1]),
    .data_i  (dat[1]),
    .valid_o (vld[2]),
    .data_o  (dat[2])
  );

  a2a_div_step u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[3]),
    .valid_i (vld[2]),
    .data_i  (dat[2]),
    .valid_o (vld[3]),
    .data_o  (dat[3])
  );

  a2a_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en[4]),
    .valid_i      (vld[3]),
    .data_i       (dat[3]),
    .valid_o      (out_valid_o),
    .angle_code_o (angle_code_o)
  );

endmodule

// ===== hdl/a2a_prep.sv =====
// ----------------------------------------------------------------------------
// a2a_prep
// Axis decode, magnitudes, octant key and scaled numerator; first stage.
// ----------------------------------------------------------------------------
module a2a_prep import a2a_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] vec_x_i,
  input  logic signed [CoordW-1:0] vec_y_i,
  output logic                     valid_o,
  output div_t                     data_o
);

  logic            xneg, yneg, near_y;
  logic [MagW-1:0] ax, ay, num;
  logic [RemW-1:0] num_x45;
  logic            valid_q;
  div_t            data_d, data_q;

  assign xneg = vec_x_i[CoordW-1];
  assign yneg = vec_y_i[CoordW-1];
  assign ax   = xneg ? (MagW'(0) - {1'b1, vec_x_i}) : {1'b0, vec_x_i};
  assign ay   = yneg ? (MagW'(0) - {1'b1, vec_y_i}) : {1'b0, vec_y_i};
  assign near_y = (ax <= ay);
  assign num    = near_y ? ax : ay;
  assign num_x45 = (RemW'(num) << 5) + (RemW'(num) << 3) + (RemW'(num) << 2) + RemW'(num);

  always_comb begin
    data_d.axis      = 1'b0;
    data_d.axis_code = CodePosY;
    if (vec_y_i == '0) begin
      data_d.axis      = 1'b1;
      data_d.axis_code = xneg ? CodeNegX : CodePosX;
    end else if (vec_x_i == '0) begin
      data_d.axis      = 1'b1;
      data_d.axis_code = yneg ? CodeNegY : CodePosY;
    end
    data_d.key = {~xneg, ~yneg, near_y};
    data_d.rem = num_x45;
    data_d.den = near_y ? ay : ax;
    data_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/a2a_div_step.sv =====
// ----------------------------------------------------------------------------
// a2a_div_step
// Two restoring division steps on a normalised remainder; one stage.
// ----------------------------------------------------------------------------
module a2a_div_step import a2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic [RemW-1:0] dsh, r0, r1, r2;
  logic            b1, b0;
  logic            valid_q;
  div_t            data_d, data_q;

  // divisor aligned to the top quotient bit
  assign dsh = {1'b0, data_i.den, 5'b0};

  assign r0 = data_i.rem;
  assign b1 = (r0 >= dsh);
  assign r1 = (b1 ? (r0 - dsh) : r0) << 1;
  assign b0 = (r1 >= dsh);
  assign r2 = (b0 ? (r1 - dsh) : r1) << 1;

  always_comb begin
    data_d     = data_i;
    data_d.rem = r2;
    data_d.quo = {data_i.quo[QuoW-3:0], b1, b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/a2a_map.sv =====
// ----------------------------------------------------------------------------
// a2a_map
// Table lookup and octant placement; drives the output register.
// ----------------------------------------------------------------------------
module a2a_map import a2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  div_t              data_i,
  output logic              valid_o,
  output logic [AngleW-1:0] angle_code_o
);

  logic [QuoW-1:0]   idx;
  logic [AngleW-1:0] base, res;
  octant_e           oct;
  logic              valid_q;
  logic [AngleW-1:0] angle_q;

  assign idx  = (data_i.quo > IdxMax) ? IdxMax : data_i.quo;
  assign base = AngleW'(AngleTab[idx]);
  assign oct  = KeyMap[data_i.key];

  always_comb begin
    unique case (oct)
      OCT_0:   res = base;
      OCT_1:   res = 8'd63 - base;
      OCT_2:   res = 8'd64 + base;
      OCT_3:   res = 8'd127 - base;
      OCT_4:   res = 8'd128 + base;
      OCT_5:   res = 8'd191 - base;
      OCT_6:   res = 8'd192 + base;
      OCT_7:   res = 8'd255 - base;
      default: res = base;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      angle_q <= data_i.axis ? data_i.axis_code : res;
    end
  end

  assign valid_o      = valid_q;
  assign angle_code_o = angle_q;

endmodule

// ===== hdl/a2a_checker.sv =====
// ----------------------------------------------------------------------------
// a2a_checker
// Port-level checks on the angle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module a2a_checker import a2a_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic signed [CoordW-1:0] vec_x_i,
  input logic signed [CoordW-1:0] vec_y_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [AngleW-1:0]        angle_code_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_code_o))
    else $error("held result changed");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input held while the pipeline can advance");

  a_pos_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_stall_i, 1) && !$past(out_stall_i, 2)
      && !$past(out_stall_i, 3) && !$past(out_stall_i, 4)
      && $past(in_acc && (vec_y_i == '0) && !vec_x_i[CoordW-1], 5)
    |-> angle_code_o == CodePosX)
    else $error("positive x axis code wrong");

  a_pos_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_stall_i, 1) && !$past(out_stall_i, 2)
      && !$past(out_stall_i, 3) && !$past(out_stall_i, 4)
      && $past(in_acc && (vec_x_i == '0) && (vec_y_i != '0) && !vec_y_i[CoordW-1], 5)
    |-> angle_code_o == CodePosY)
    else $error("positive y axis code wrong");

endmodule

bind atan2_to_8bit_angle a2a_checker u_a2a_checker (.*);
